### rtl/core/trlru_pkg.sv
// ----------------------------------------------------------------------------
// trlru_pkg
// Shared sizes, opcode values and types for the timestamp LRU replacement unit.
// ----------------------------------------------------------------------------
package trlru_pkg;

	// Geometry. SETS must be a power of two; the set field is cut to SET_W bits.
	localparam int SETS     = 1024;
	localparam int WAYS     = 16;

	localparam int SET_W    = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int LVL      = $clog2(WAYS);
	localparam int WAY_W    = LVL;
	localparam int WAYS_P2  = 1 << LVL;
	localparam int LVL_CW   = (LVL > 1) ? $clog2(LVL) : 1;

	// Port field widths.
	localparam int OPC_W    = 2;
	localparam int SETIN_W  = 10;
	localparam int WAYIN_W  = 5;
	localparam int VICTIM_W = 4;
	localparam int STAMP_W  = 64;

	localparam int RESQ_DEPTH = 2;

	// Opcodes.
	localparam logic [OPC_W-1:0] OP_VICTIM = 2'd0;
	localparam logic [OPC_W-1:0] OP_FILL   = 2'd1;
	localparam logic [OPC_W-1:0] OP_ACCESS = 2'd2;

	typedef enum logic [1:0] {
		CMD_NONE,
		CMD_VICTIM,
		CMD_STAMP
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t        kind;
		logic [SET_W-1:0] set;
		logic [WAY_W-1:0] way;
	} cmd_t;

	typedef enum logic [1:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_REDUCE
	} back_state_t;

	typedef struct packed {
		logic [STAMP_W-1:0] stamp;
		logic [WAY_W-1:0]   way;
	} cand_t;

endpackage

### rtl/core/trlru_front.sv
// ----------------------------------------------------------------------------
// trlru_front
// Accepts items, decodes them into back-end commands and queues them.
// ----------------------------------------------------------------------------
module trlru_front
	import trlru_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [OPC_W-1:0]   opcode,
	input  logic [SETIN_W-1:0] set_index,
	input  logic [WAYIN_W-1:0] way_index,
	input  logic               is_write,
	input  logic               was_hit,
	input  logic               clearing,
	output cmd_t               cmd,
	output logic               cmd_valid,
	input  logic               cmd_pop
);

	cmd_t       cls;
	logic       way_ok;
	logic       accept;
	cmd_t       q_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	always_comb begin
		way_ok    = {1'b0, way_index} < (WAYIN_W+1)'(WAYS);
		cls.set   = set_index[SET_W-1:0];
		cls.way   = way_index[WAY_W-1:0];
		case (opcode)
			OP_VICTIM: cls.kind = CMD_VICTIM;
			OP_FILL:   cls.kind = way_ok ? CMD_STAMP : CMD_NONE;
			OP_ACCESS: cls.kind = (way_ok && was_hit && !is_write) ? CMD_STAMP : CMD_NONE;
			default:   cls.kind = CMD_NONE;
		endcase
	end

	assign full      = clearing || (cnt_q == 2'd2);
	assign accept    = push && !full;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = q_q[rp_q];

	always_ff @(posedge clk) begin
		if (accept) begin
			q_q[wp_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (accept) begin
				wp_q <= ~wp_q;
			end
			if (cmd_pop) begin
				rp_q <= ~rp_q;
			end
			case ({accept, cmd_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### rtl/core/trlru_back.sv
// ----------------------------------------------------------------------------
// trlru_back
// Stamp memory, stamp counter and oldest-way search, one command at a time.
// ----------------------------------------------------------------------------
module trlru_back
	import trlru_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	input  logic                cmd_valid,
	output logic                cmd_pop,
	output logic                clearing,
	output logic                res_push,
	output logic [VICTIM_W-1:0] res_way,
	input  logic                res_full
);

	logic [WAYS-1:0][STAMP_W-1:0] mem [SETS];
	logic [WAYS-1:0][STAMP_W-1:0] rd_row_q;

	back_state_t        state_q, state_d;
	logic [SET_W-1:0]   clr_q;
	logic [LVL_CW-1:0]  lvl_q;
	logic [STAMP_W-1:0] counter_q;
	cand_t              cand_q [WAYS_P2];

	logic               wr_en;
	logic [SET_W-1:0]   wr_addr;
	logic [WAYS-1:0]    wr_mask;
	logic [STAMP_W-1:0] wr_data;
	logic               rd_en;
	logic               count_en;
	logic               clr_adv;
	logic               lvl_adv;
	logic               last_lvl;

	cand_t              src [WAYS_P2];
	cand_t              red [WAYS_P2];

	// Row memory, one lane per way.
	always_ff @(posedge clk) begin
		for (int w = 0; w < WAYS; w++) begin
			if (wr_en && wr_mask[w]) begin
				mem[wr_addr][w] <= wr_data;
			end
		end
		if (rd_en) begin
			rd_row_q <= mem[cmd.set];
		end
	end

	// One tree level per cycle; the right candidate wins only when strictly older.
	always_comb begin
		for (int i = 0; i < WAYS_P2; i++) begin
			if (lvl_q == '0) begin
				src[i].stamp = (i < WAYS) ? rd_row_q[i % WAYS] : '1;
				src[i].way   = WAY_W'(i);
			end else begin
				src[i] = cand_q[i];
			end
		end
		for (int i = 0; i < WAYS_P2; i++) begin
			if (i < WAYS_P2 / 2) begin
				red[i] = (src[2*i+1].stamp < src[2*i].stamp) ? src[2*i+1] : src[2*i];
			end else begin
				red[i] = src[i];
			end
		end
	end

	assign last_lvl = (lvl_q == LVL_CW'(LVL - 1));
	assign clearing = (state_q == BK_CLEAR);

	always_comb begin
		state_d  = state_q;
		wr_en    = 1'b0;
		wr_addr  = cmd.set;
		wr_mask  = '0;
		wr_data  = counter_q;
		rd_en    = 1'b0;
		cmd_pop  = 1'b0;
		res_push = 1'b0;
		res_way  = '0;
		count_en = 1'b0;
		clr_adv  = 1'b0;
		lvl_adv  = 1'b0;
		case (state_q)
			BK_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				wr_mask = '1;
				wr_data = '0;
				clr_adv = 1'b1;
				if (clr_q == SET_W'(SETS - 1)) begin
					state_d = BK_IDLE;
				end
			end
			BK_IDLE: begin
				if (cmd_valid) begin
					case (cmd.kind)
						CMD_VICTIM: begin
							rd_en   = 1'b1;
							cmd_pop = 1'b1;
							state_d = BK_REDUCE;
						end
						CMD_STAMP: begin
							if (!res_full) begin
								wr_en             = 1'b1;
								wr_mask[cmd.way]  = 1'b1;
								count_en          = 1'b1;
								cmd_pop           = 1'b1;
								res_push          = 1'b1;
							end
						end
						default: begin
							if (!res_full) begin
								cmd_pop  = 1'b1;
								res_push = 1'b1;
							end
						end
					endcase
				end
			end
			BK_REDUCE: begin
				if (last_lvl) begin
					// Hold the final level until the result queue has room.
					if (!res_full) begin
						res_push = 1'b1;
						res_way  = VICTIM_W'(red[0].way);
						state_d  = BK_IDLE;
					end
				end else begin
					lvl_adv = 1'b1;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (lvl_adv) begin
			for (int i = 0; i < WAYS_P2; i++) begin
				cand_q[i] <= red[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_CLEAR;
			clr_q     <= '0;
			lvl_q     <= '0;
			counter_q <= '0;
		end else begin
			state_q <= state_d;
			if (clr_adv) begin
				clr_q <= clr_q + SET_W'(1);
			end
			if (count_en) begin
				counter_q <= counter_q + STAMP_W'(1);
			end
			if (rd_en || (res_push && state_q == BK_REDUCE)) begin
				lvl_q <= '0;
			end else if (lvl_adv) begin
				lvl_q <= lvl_q + LVL_CW'(1);
			end
		end
	end

endmodule

### rtl/core/trlru_resq.sv
// ----------------------------------------------------------------------------
// trlru_resq
// Two-entry result queue between the back end and the result ports.
// ----------------------------------------------------------------------------
module trlru_resq
	import trlru_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr,
	input  logic [VICTIM_W-1:0] wr_way,
	output logic                q_full,
	input  logic                rd,
	output logic                q_empty,
	output logic [VICTIM_W-1:0] rd_way
);

	logic [VICTIM_W-1:0] q_q [RESQ_DEPTH];
	logic                wp_q;
	logic                rp_q;
	logic [1:0]          cnt_q;
	logic                do_rd;

	assign q_full  = (cnt_q == 2'(RESQ_DEPTH));
	assign q_empty = (cnt_q == 2'd0);
	assign rd_way  = q_q[rp_q];
	assign do_rd   = rd && !q_empty;

	always_ff @(posedge clk) begin
		if (wr) begin
			q_q[wp_q] <= wr_way;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) begin
				wp_q <= ~wp_q;
			end
			if (do_rd) begin
				rp_q <= ~rp_q;
			end
			case ({wr, do_rd})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### rtl/core/timestamp_lru_replacement_unit.sv
// ----------------------------------------------------------------------------
// timestamp_lru_replacement_unit
// Timestamp LRU replacement: per-way stamps, victim search, fill and touch.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue: drive an item and raise push; it is taken on a
//   clock edge where full is low. Every item gives exactly one result on
//   the output queue (empty/pop, victim_way), in order; only victim requests
//   carry a nonzero way.
//   Order: a fill, access or unused opcode is done as soon as the back end
//   takes it; a victim request first does the registered row read of the
//   stamp memory, then walks the comparison tree one level per cycle; the
//   tree is the shared unit that sets the rate. While a search runs, the
//   command queue keeps taking items until it fills. The back end works on
//   the head of the command queue directly.
//   Reset: the stamp memory is cleared row by row, all SETS (1024) rows;
//   full stays high during that pass. The stamp counter resets to zero.
//   Stall: results wait in a two-entry queue; when it fills the back end
//   holds, the two-entry command queue fills, and full rises.
// ----------------------------------------------------------------------------
module timestamp_lru_replacement_unit
	import trlru_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic [OPC_W-1:0]    opcode,
	input  logic [SETIN_W-1:0]  set_index,
	input  logic [WAYIN_W-1:0]  way_index,
	input  logic                is_write,
	input  logic                was_hit,
	output logic                empty,
	input  logic                pop,
	output logic [VICTIM_W-1:0] victim_way
);

	cmd_t                cmd;
	logic                cmd_valid;
	logic                cmd_pop;
	logic                clearing;
	logic                res_push;
	logic [VICTIM_W-1:0] res_way;
	logic                res_full;

	trlru_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.opcode    (opcode),
		.set_index (set_index),
		.way_index (way_index),
		.is_write  (is_write),
		.was_hit   (was_hit),
		.clearing  (clearing),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop)
	);

	trlru_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.clearing  (clearing),
		.res_push  (res_push),
		.res_way   (res_way),
		.res_full  (res_full)
	);

	trlru_resq u_resq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (res_push),
		.wr_way  (res_way),
		.q_full  (res_full),
		.rd      (pop),
		.q_empty (empty),
		.rd_way  (victim_way)
	);

endmodule

### rtl/core/trlru_chk.sv
// ----------------------------------------------------------------------------
// trlru_chk
// Port-level checks for the timestamp LRU replacement unit.
// ----------------------------------------------------------------------------
module trlru_chk
	import trlru_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                push,
	input logic                full,
	input logic                pop,
	input logic                empty,
	input logic [VICTIM_W-1:0] victim_way
);

	logic [3:0] pend_q;
	logic       acc_in;
	logic       acc_out;

	assign acc_in  = push && !full;
	assign acc_out = pop && !empty;

	// Track items taken but not yet delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			case ({acc_in, acc_out})
				2'b10:   pend_q <= pend_q + 4'd1;
				2'b01:   pend_q <= pend_q - 4'd1;
				default: pend_q <= pend_q;
			endcase
		end
	end

	a_no_invented_result: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> pend_q != 4'd0)
		else $error("result shown with no item outstanding");

	a_full_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> full)
		else $error("input open while stamp memory is being cleared");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty)
		else $error("waiting result dropped");

	a_way_held: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> $stable(victim_way))
		else $error("waiting result changed");

endmodule

bind timestamp_lru_replacement_unit trlru_chk u_chk (.*);

### bench/timestamp_lru_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timestamp_lru_checker
// Watches both queue ports of the replacement unit. Every accepted item runs
// through a local copy of the per-way stamps and the stamp counter. The
// victim way it yields is queued, and each popped result is compared with
// the oldest entry in that queue.
// ----------------------------------------------------------------------------
module timestamp_lru_checker
	import trlru_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic                full,
	input  logic [OPC_W-1:0]    opcode,
	input  logic [SETIN_W-1:0]  set_index,
	input  logic [WAYIN_W-1:0]  way_index,
	input  logic                is_write,
	input  logic                was_hit,
	input  logic                empty,
	input  logic                pop,
	input  logic [VICTIM_W-1:0] victim_way,
	output int                  fail_count,
	output int                  pending_results
);

	logic [STAMP_W-1:0]  way_stamp [SETS][WAYS];
	logic [STAMP_W-1:0]  stamp_count;
	logic [VICTIM_W-1:0] victim_queue [$];

	assign pending_results = victim_queue.size();

	// Lowest way wins a tie, so only a strictly older stamp moves the pick.
	function automatic logic [VICTIM_W-1:0] oldest_way(input int set);
		int best;
		int w;
		best = 0;
		for (w = 1; w < WAYS; w++)
			if (way_stamp[set][w] < way_stamp[set][best])
				best = w;
		return VICTIM_W'(best);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		int                  set;
		int                  s;
		int                  w;
		logic                touch;
		logic [VICTIM_W-1:0] want;
		if (!arst_n) begin
			for (s = 0; s < SETS; s++)
				for (w = 0; w < WAYS; w++)
					way_stamp[s][w] = '0;
			stamp_count = '0;
			victim_queue.delete();
			fail_count = 0;
		end else begin
			if (push && !full) begin
				set   = int'(set_index) % SETS;
				want  = '0;
				touch = 1'b0;
				case (opcode)
					OP_VICTIM: want  = oldest_way(set);
					OP_FILL:   touch = 1'b1;
					OP_ACCESS: touch = was_hit && !is_write;
					default:   ;
				endcase
				// bypass and out-of-range ways leave stamps and counter alone
				if (touch && int'(way_index) < WAYS) begin
					way_stamp[set][way_index[WAY_W-1:0]] = stamp_count;
					stamp_count = stamp_count + STAMP_W'(1);
				end
				victim_queue = {victim_queue, want};
			end
			if (pop && !empty) begin
				if (victim_queue.size() == 0) begin
					$error("victim_way: result %0d with no item outstanding", victim_way);
					fail_count++;
				end else begin
					want = victim_queue.pop_front();
					if (victim_way !== want) begin
						$error("victim_way: expected %0d, got %0d", want, victim_way);
						fail_count++;
					end
				end
			end
		end
	end

endmodule

### bench/tb_timestamp_lru_replacement_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_timestamp_lru_replacement_unit
// Drives victim requests, fills and access updates into the replacement unit:
// a directed opening over the corner cases, then random traffic that mostly
// hammers a few hot sets so victims depend on real stamp history. Both sides
// idle at random; the checker beside the unit predicts and compares.
// ----------------------------------------------------------------------------
module tb_timestamp_lru_replacement_unit;
	import trlru_pkg::*;

	localparam logic [OPC_W-1:0] OP_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS   = 430;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES  = 16;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                push      = 1'b0;
	logic [OPC_W-1:0]    opcode    = '0;
	logic [SETIN_W-1:0]  set_index = '0;
	logic [WAYIN_W-1:0]  way_index = '0;
	logic                is_write  = 1'b0;
	logic                was_hit   = 1'b0;
	logic                pop       = 1'b0;
	logic                full;
	logic                empty;
	logic [VICTIM_W-1:0] victim_way;
	int                  fail_count;
	int                  pending_results;
	int                  idle_cycles = 0;
	int                  send_calm   = 0;
	int                  take_calm   = 0;

	logic [SETIN_W-1:0] hot_sets [6] = '{10'd0, 10'd1, 10'd77, 10'd512, 10'd1022, 10'd1023};

	always #1 clk = ~clk;

	timestamp_lru_replacement_unit uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.opcode     (opcode),
		.set_index  (set_index),
		.way_index  (way_index),
		.is_write   (is_write),
		.was_hit    (was_hit),
		.empty      (empty),
		.pop        (pop),
		.victim_way (victim_way)
	);

	timestamp_lru_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.push            (push),
		.full            (full),
		.opcode          (opcode),
		.set_index       (set_index),
		.way_index       (way_index),
		.is_write        (is_write),
		.was_hit         (was_hit),
		.empty           (empty),
		.pop             (pop),
		.victim_way      (victim_way),
		.fail_count      (fail_count),
		.pending_results (pending_results)
	);

	// Mostly random gaps, with occasional runs of back-to-back items.
	function automatic int draw_gap(inout int calm_left);
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		if ($urandom_range(0, 19) == 0) begin
			calm_left = $urandom_range(8, 40);
			return 0;
		end
		return $urandom_range(0, 17);
	endfunction

	task automatic send_item(input logic [OPC_W-1:0] op, input logic [SETIN_W-1:0] set,
			input logic [WAYIN_W-1:0] way, input logic wr, input logic hit);
		int gap;
		gap = draw_gap(send_calm);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push      <= 1'b1;
		opcode    <= op;
		set_index <= set;
		way_index <= way;
		is_write  <= wr;
		was_hit   <= hit;
		do @(posedge clk); while (full);
	endtask

	task automatic send_random_item();
		int                 pick;
		logic [OPC_W-1:0]   op;
		logic [SETIN_W-1:0] set;
		logic [WAYIN_W-1:0] way;
		pick = $urandom_range(0, 99);
		if (pick < 35)
			op = OP_VICTIM;
		else if (pick < 65)
			op = OP_FILL;
		else if (pick < 95)
			op = OP_ACCESS;
		else
			op = OP_UNUSED;
		if ($urandom_range(0, 9) < 7)
			set = hot_sets[$urandom_range(0, 5)];
		else
			set = SETIN_W'($urandom_range(0, (1 << SETIN_W) - 1));
		if ($urandom_range(0, 9) < 9)
			way = WAYIN_W'($urandom_range(0, WAYS - 1));
		else
			way = WAYIN_W'($urandom_range(WAYS, (1 << WAYIN_W) - 1));
		send_item(op, set, way, $urandom_range(0, 4) == 0, $urandom_range(0, 4) != 0);
	endtask

	// Hold off the sender until every outstanding result has been popped.
	task automatic wait_drained();
		push <= 1'b0;
		do @(posedge clk); while (pending_results != 0);
	endtask

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("timestamp_lru_replacement_unit verification failed");
			$finish;
		end
	end

	initial begin
		@(posedge arst_n);
		forever begin
			int gap;
			gap = draw_gap(take_calm);
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
		end
	end

	initial begin
		int i;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// untouched set: all stamps tie at zero
		send_item(OP_VICTIM, 10'd0, 5'd0, 1'b0, 1'b0);
		send_item(OP_FILL, 10'd0, 5'd0, 1'b0, 1'b0);
		send_item(OP_FILL, 10'd0, 5'd15, 1'b0, 1'b0);
		send_item(OP_ACCESS, 10'd0, 5'd0, 1'b0, 1'b1);
		send_item(OP_VICTIM, 10'd0, 5'd31, 1'b1, 1'b1);
		// bypass fill and ways beyond the array
		send_item(OP_FILL, 10'd1023, 5'd16, 1'b0, 1'b0);
		send_item(OP_FILL, 10'd1023, 5'd31, 1'b1, 1'b1);
		send_item(OP_ACCESS, 10'd1023, 5'd16, 1'b0, 1'b1);
		send_item(OP_ACCESS, 10'd1023, 5'd31, 1'b0, 1'b1);
		send_item(OP_FILL, 10'd1023, 5'd0, 1'b0, 1'b0);
		send_item(OP_FILL, 10'd1023, 5'd1, 1'b0, 1'b0);
		send_item(OP_VICTIM, 10'd1023, 5'd0, 1'b0, 1'b0);
		// writeback hit and misses must not refresh the way
		send_item(OP_ACCESS, 10'd1023, 5'd2, 1'b1, 1'b1);
		send_item(OP_ACCESS, 10'd1023, 5'd2, 1'b0, 1'b0);
		send_item(OP_ACCESS, 10'd1023, 5'd2, 1'b1, 1'b0);
		send_item(OP_VICTIM, 10'd1023, 5'd0, 1'b0, 1'b0);
		send_item(OP_UNUSED, 10'd1023, 5'd31, 1'b1, 1'b1);
		send_item(OP_ACCESS, 10'd1023, 5'd2, 1'b0, 1'b1);
		send_item(OP_VICTIM, 10'd1023, 5'd0, 1'b0, 1'b0);
		send_item(OP_ACCESS, 10'd1, 5'd15, 1'b0, 1'b1);
		send_item(OP_VICTIM, 10'd1, 5'd0, 1'b0, 1'b0);
		wait_drained();

		for (i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 150 == 75)
				wait_drained();
			send_random_item();
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending_results == 0)
			$display("timestamp_lru_replacement_unit verification clean");
		else
			$display("timestamp_lru_replacement_unit verification failed");
		$finish;
	end

endmodule
